/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the depacketizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RTPD_AST_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtpd same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RTPD_AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtpd next-cycle check failed");

`endif

/* rtl/rtpd_pkg.sv */
// Shared types and constants of the RTP H.264 depacketizer.
`default_nettype none

package rtpd_pkg;

  // Index of the NAL header word within a start-code burst
  localparam logic [2:0] UNIT_LAST_IDX = 3'd4;

  // What one packet word produces for the output stage
  typedef struct packed {
    logic       emit;   // word produces output
    logic       unit;   // start code + header, else a single payload word
    logic [7:0] data;   // payload word or rebuilt NAL header
  } burst_t;

endpackage

`default_nettype wire

/* rtl/rtpd_parse.sv */
// Packet parser: RTP header skip and NAL payload type handling.
`default_nettype none

module rtpd_parse (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire [7:0]         data_byte,
  input  wire               packet_start,
  input  wire               packet_end,
  output rtpd_pkg::burst_t  burst
);

  localparam logic [3:0] PH_WAIT      = 4'd0;
  localparam logic [3:0] PH_HEADER    = 4'd1;
  localparam logic [3:0] PH_NAL       = 4'd2;
  localparam logic [3:0] PH_PASS      = 4'd3;
  localparam logic [3:0] PH_FU_HDR    = 4'd4;
  localparam logic [3:0] PH_LEN_HI    = 4'd5;
  localparam logic [3:0] PH_LEN_LO    = 4'd6;
  localparam logic [3:0] PH_UNIT_HEAD = 4'd7;
  localparam logic [3:0] PH_UNIT_BODY = 4'd8;
  localparam logic [3:0] PH_DROP      = 4'd9;

  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A   = 5'd28;

  localparam logic [6:0] RTP_FIXED_LEN = 7'd12;

  logic [3:0]  phase_r,   phase_nxt;
  logic [6:0]  hcnt_r,    hcnt_nxt;
  logic [3:0]  csrc_r,    csrc_nxt;
  logic [2:0]  f_nri_r,   f_nri_nxt;
  logic [7:0]  len_hi_r,  len_hi_nxt;
  logic [15:0] remain_r,  remain_nxt;

  logic [15:0] remain_dec;
  logic [6:0]  hdr_len;
  logic [4:0]  nal_type;

  assign remain_dec = remain_r - 16'd1;
  assign nal_type   = data_byte[4:0];
  // RTP header length: 12 bytes plus 4 per CSRC of the packet in progress
  assign hdr_len    = RTP_FIXED_LEN +
                      {1'b0, (packet_start ? data_byte[3:0] : csrc_r), 2'b00};

  // Next state and output burst for the current word
  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    csrc_nxt   = csrc_r;
    f_nri_nxt  = f_nri_r;
    len_hi_nxt = len_hi_r;
    remain_nxt = remain_r;
    burst.emit = 1'b0;
    burst.unit = 1'b0;
    burst.data = data_byte;

    if (packet_start) begin
      csrc_nxt  = data_byte[3:0];
      hcnt_nxt  = 7'd1;
      phase_nxt = PH_HEADER;
    end else begin
      unique case (phase_r)
        PH_HEADER: hcnt_nxt = hcnt_r + 7'd1;
        PH_NAL: begin
          if (nal_type == NAL_SPS || nal_type == NAL_PPS) begin
            burst.emit = 1'b1;
            burst.unit = 1'b1;
            phase_nxt  = PH_PASS;
          end else if (nal_type == NAL_STAP_A) begin
            phase_nxt = PH_LEN_HI;
          end else if (nal_type == NAL_FU_A) begin
            f_nri_nxt = data_byte[7:5];
            phase_nxt = PH_FU_HDR;
          end else begin
            phase_nxt = PH_DROP;
          end
        end
        PH_PASS: burst.emit = 1'b1;
        PH_FU_HDR: begin
          // header rebuilt only on the start fragment
          burst.emit = data_byte[7];
          burst.unit = 1'b1;
          burst.data = {f_nri_r, data_byte[4:0]};
          phase_nxt  = PH_PASS;
        end
        PH_LEN_HI: begin
          len_hi_nxt = data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          remain_nxt = {len_hi_r, data_byte};
          // zero-length unit is skipped
          phase_nxt  = ({len_hi_r, data_byte} != 16'd0) ? PH_UNIT_HEAD : PH_LEN_HI;
        end
        PH_UNIT_HEAD: begin
          burst.emit = 1'b1;
          burst.unit = 1'b1;
          remain_nxt = remain_dec;
          phase_nxt  = (remain_dec != 16'd0) ? PH_UNIT_BODY : PH_LEN_HI;
        end
        PH_UNIT_BODY: begin
          burst.emit = 1'b1;
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0) begin
            phase_nxt = PH_LEN_HI;
          end
        end
        default: ;  // wait and drop: word ignored
      endcase
    end

    if (phase_nxt == PH_HEADER && hcnt_nxt >= hdr_len) begin
      phase_nxt = PH_NAL;
    end
    if (packet_end) begin
      phase_nxt = PH_WAIT;
    end
  end

  // State registers, advanced once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      hcnt_r   <= 7'd0;
      csrc_r   <= 4'd0;
      f_nri_r  <= 3'd0;
      len_hi_r <= 8'd0;
      remain_r <= 16'd0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      csrc_r   <= csrc_nxt;
      f_nri_r  <= f_nri_nxt;
      len_hi_r <= len_hi_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rtp_h264_depacketizer.sv */
// RTP H.264 depacketizer: RTP packet words in, Annex-B stream words out.
// Accepted input words pass the input word register, then the output burst register.
// Throughput: one input word per cycle for pass-through payload while out_stall is low;
// a word opening a NAL unit holds the burst register through start code and header.
// Reset (synchronous, rst_n low): parser waits for a packet start, both
// pipeline registers empty.
`default_nettype none
`include "assert_macros.svh"

module rtp_h264_depacketizer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_data_byte,
  input  wire        in_packet_start,
  input  wire        in_packet_end,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_byte,
  output logic       out_unit_start,
  output logic       out_run_last
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       in_end_r;

  logic       busy_r;
  logic       unit_r;
  logic [7:0] data_r;
  logic [2:0] idx_r;

  logic             in_acc;
  logic             take;
  logic             is_last;
  logic             last_taken;
  rtpd_pkg::burst_t burst;

  // Output burst bookkeeping
  assign is_last    = !unit_r || (idx_r == rtpd_pkg::UNIT_LAST_IDX);
  assign last_taken = busy_r && !out_stall && is_last;
  // Input register moves into the parser when the burst register frees up
  assign take       = in_vld_r && (!busy_r || last_taken);
  assign in_stall   = in_vld_r && !take;
  assign in_acc     = in_valid && !in_stall;

  rtpd_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (take),
    .data_byte    (in_byte_r),
    .packet_start (in_start_r),
    .packet_end   (in_end_r),
    .burst        (burst)
  );

  // Input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_packet_start;
      in_end_r   <= in_packet_end;
    end
  end

  // Result burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (take && burst.emit) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (last_taken) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (busy_r && !out_stall) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && burst.emit) begin
      unit_r <= burst.unit;
      data_r <= burst.data;
    end
  end

  // Start code 00 00 00 01, then the NAL header; else the payload word
  always_comb begin
    out_byte = 8'h00;
    if (!unit_r || idx_r == rtpd_pkg::UNIT_LAST_IDX) begin
      out_byte = data_r;
    end else if (idx_r == 3'd3) begin
      out_byte = 8'h01;
    end
  end

  assign out_valid      = busy_r;
  assign out_unit_start = unit_r && (idx_r == 3'd0);
  assign out_run_last   = is_last;

  // A single payload word never advances past the first slot
  `RTPD_AST_SAME(a_single_idx, clk, rst_n, busy_r && !unit_r, idx_r == 3'd0)
  // Burst index stays within the start code plus header
  `RTPD_AST_SAME(a_idx_range, clk, rst_n, busy_r, idx_r <= rtpd_pkg::UNIT_LAST_IDX)
  // Last word taken with no new burst loaded leaves the output empty
  `RTPD_AST_NEXT(a_drain, clk, rst_n, last_taken && !(take && burst.emit), !busy_r)
  // An unprocessed input word is held until the parser takes it
  `RTPD_AST_NEXT(a_hold, clk, rst_n, in_vld_r && !take, in_vld_r)

endmodule

`default_nettype wire
